>>> sv/alir_pkg.sv
// Shared command and status codes for the array list insert/remove block.
package alir_pkg;

  localparam int WORD_W  = 32;
  localparam int CMD_W   = 3;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int EPOS_W  = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 4;

  // Command codes; the two unused codes behave as a query.
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REPLACE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SHIFT  = 5'b00010,
    S_FIN    = 5'b00100,
    S_EMIT   = 5'b01000,
    S_SINGLE = 5'b10000
  } state_t;

endpackage

>>> sv/array_list_insert_remove.sv
// Top level of the bounded ordered list with insert, remove, replace and query commands.
// An error leads straight to its single result; otherwise entries shift where needed, the
//   command commits, and the list streams out, or a lone result marks a list left empty.
// A new command is taken only once the last result is registered; the store's single read port
//   both shifts entries and streams the list out, one per cycle while out_tready stays high.
// Reset (rst_n low, synchronous) empties the list; the store itself is not cleared.
module array_list_insert_remove
  import alir_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0], position[35:32], zero fill
  input  logic [CMD_W-1:0]       in_tuser,   // command[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // entry_position[2:0], entry_value[34:3], zero fill
  output logic [OUT_TUSER_W-1:0] out_tuser,  // status[1:0], entry_present[2], is_empty[3]
  output logic                   out_tlast   // last
);

  // Index width for the store, and a count width that can hold CAPACITY itself.
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // Common width for comparing the position field against the count.
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t state_r, state_nxt;

  logic [CW-1:0]     count_r, count_nxt;
  logic              is_ins_r, is_ins_nxt;
  logic              is_rem_r, is_rem_nxt;
  logic              wr_val_r, wr_val_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [STAT_W-1:0] err_r, err_nxt;

  // Shift sequencer: destination pointer and moves still to issue.
  logic [CW-1:0]     sh_left_r, sh_left_nxt;
  logic [IW-1:0]     dst_r, dst_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [IW-1:0]     wr_dst_r, wr_dst_nxt;

  // Emission: next index to read, and the tag of the word in the read register.
  logic [CW-1:0]     emit_idx_r, emit_idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]     rd_pos_r, rd_pos_nxt;
  logic              rd_last_r, rd_last_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic                  out_present_r, out_present_nxt;
  logic [EPOS_W-1:0]     out_epos_r, out_epos_nxt;
  logic [WORD_W-1:0]     out_value_r, out_value_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic                  out_last_r, out_last_nxt;

  // Store ports.
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_q;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  // Command decode on the input fields.
  logic [CMD_W-1:0]  in_cmd;
  logic [POS_W-1:0]  in_pos;
  logic [WORD_W-1:0] in_val;
  logic              full;
  logic              pos_above;
  logic              pos_not_below;
  logic [STAT_W-1:0] acc_err;
  logic [IW-1:0]     acc_pos;
  logic [CW-1:0]     acc_moves;
  logic [IW-1:0]     acc_dst;
  logic              acc_ins;
  logic              acc_rem;
  logic              acc_wr;

  logic in_fire;
  logic out_fire;
  logic out_free;
  logic move;
  logic issue;

  assign in_cmd = in_tuser;
  assign in_val = in_tdata[WORD_W-1:0];
  assign in_pos = in_tdata[WORD_W+POS_W-1:WORD_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  // The output register can take a new result at this edge.
  assign out_free  = !out_valid_r || out_fire;

  assign full          = (count_r >= CAP_C);
  assign pos_above     = (XW'(in_pos) > XW'(count_r));
  assign pos_not_below = (XW'(in_pos) >= XW'(count_r));

  always_comb begin
    acc_err   = ST_OK;
    acc_pos   = '0;
    acc_moves = '0;
    acc_dst   = '0;
    acc_ins   = 1'b0;
    acc_rem   = 1'b0;
    acc_wr    = 1'b0;
    case (in_cmd)
      CMD_INS_FRONT: begin
        if (full) begin
          acc_err = ST_FULL;
        end else begin
          acc_ins   = 1'b1;
          acc_wr    = 1'b1;
          acc_moves = count_r;
          acc_dst   = IW'(count_r);
        end
      end
      CMD_INS_END: begin
        if (full) begin
          acc_err = ST_FULL;
        end else begin
          acc_ins = 1'b1;
          acc_wr  = 1'b1;
          acc_pos = IW'(count_r);
        end
      end
      CMD_INS_AT: begin
        // A full list is reported before the position is looked at.
        if (full) begin
          acc_err = ST_FULL;
        end else if (pos_above) begin
          acc_err = ST_RANGE;
        end else begin
          acc_ins   = 1'b1;
          acc_wr    = 1'b1;
          acc_pos   = IW'(in_pos);
          acc_moves = count_r - CW'(in_pos);
          acc_dst   = IW'(count_r);
        end
      end
      CMD_REMOVE: begin
        if (pos_not_below) begin
          acc_err = ST_RANGE;
        end else begin
          acc_rem   = 1'b1;
          acc_pos   = IW'(in_pos);
          acc_moves = count_r - CW'(in_pos) - CW'(1);
          acc_dst   = IW'(in_pos);
        end
      end
      CMD_REPLACE: begin
        if (pos_not_below) begin
          acc_err = ST_RANGE;
        end else begin
          acc_wr  = 1'b1;
          acc_pos = IW'(in_pos);
        end
      end
      default: begin
        // Query and the unused codes change nothing and emit the list.
      end
    endcase
  end

  // An emitted word moves from the read register into the output register.
  assign move  = (state_r == S_EMIT) && rd_pend_r && out_free;
  assign issue = (state_r == S_EMIT) && (emit_idx_r != count_r) && (!rd_pend_r || move);

  // Store port selection. A shift write never overwrites an entry that is still to be moved.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_r == S_SHIFT && sh_left_r != '0) begin
      rd_en   = 1'b1;
      rd_addr = is_rem_r ? dst_r + IW'(1) : dst_r - IW'(1);
    end else if (issue) begin
      rd_en   = 1'b1;
      rd_addr = IW'(emit_idx_r);
    end
  end

  assign wr_en   = wr_pend_r || (state_r == S_FIN && wr_val_r);
  assign wr_addr = wr_pend_r ? wr_dst_r : pos_r;
  assign wr_data = wr_pend_r ? rd_q : val_r;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    is_ins_nxt      = is_ins_r;
    is_rem_nxt      = is_rem_r;
    wr_val_nxt      = wr_val_r;
    val_nxt         = val_r;
    pos_nxt         = pos_r;
    err_nxt         = err_r;
    sh_left_nxt     = sh_left_r;
    dst_nxt         = dst_r;
    wr_pend_nxt     = 1'b0;
    wr_dst_nxt      = wr_dst_r;
    emit_idx_nxt    = emit_idx_r;
    rd_pend_nxt     = rd_pend_r;
    rd_pos_nxt      = rd_pos_r;
    rd_last_nxt     = rd_last_r;
    out_valid_nxt   = out_fire ? 1'b0 : out_valid_r;
    out_status_nxt  = out_status_r;
    out_present_nxt = out_present_r;
    out_epos_nxt    = out_epos_r;
    out_value_nxt   = out_value_r;
    out_empty_nxt   = out_empty_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          is_ins_nxt  = acc_ins;
          is_rem_nxt  = acc_rem;
          wr_val_nxt  = acc_wr;
          val_nxt     = in_val;
          pos_nxt     = acc_pos;
          err_nxt     = acc_err;
          sh_left_nxt = acc_moves;
          dst_nxt     = acc_dst;
          if (acc_err != ST_OK) begin
            state_nxt = S_SINGLE;
          end else if (acc_moves != '0) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SHIFT: begin
        // One move issued a cycle; its write lands in the cycle after its read.
        if (sh_left_r != '0) begin
          wr_pend_nxt = 1'b1;
          wr_dst_nxt  = dst_r;
          dst_nxt     = is_rem_r ? dst_r + IW'(1) : dst_r - IW'(1);
          sh_left_nxt = sh_left_r - CW'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (is_ins_r) begin
          count_nxt = count_r + CW'(1);
        end else if (is_rem_r) begin
          count_nxt = count_r - CW'(1);
        end
        emit_idx_nxt = '0;
        rd_pend_nxt  = 1'b0;
        state_nxt    = (count_nxt == '0) ? S_SINGLE : S_EMIT;
      end
      S_EMIT: begin
        if (move) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_present_nxt = 1'b1;
          out_epos_nxt    = EPOS_W'(rd_pos_r);
          out_value_nxt   = rd_q;
          out_empty_nxt   = 1'b0;
          out_last_nxt    = rd_last_r;
        end
        if (issue) begin
          rd_pos_nxt   = IW'(emit_idx_r);
          rd_last_nxt  = ((emit_idx_r + CW'(1)) == count_r);
          emit_idx_nxt = emit_idx_r + CW'(1);
        end
        rd_pend_nxt = issue || (rd_pend_r && !move);
        if (!issue && !rd_pend_nxt) begin
          state_nxt = S_IDLE;
        end
      end
      S_SINGLE: begin
        // Error result, or the lone result of a list left empty.
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = err_r;
          out_present_nxt = 1'b0;
          out_epos_nxt    = '0;
          out_value_nxt   = '0;
          out_empty_nxt   = (count_r == '0);
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sh_left_r   <= '0;
      wr_pend_r   <= 1'b0;
      emit_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sh_left_r   <= sh_left_nxt;
      wr_pend_r   <= wr_pend_nxt;
      emit_idx_r  <= emit_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_ins_r      <= is_ins_nxt;
    is_rem_r      <= is_rem_nxt;
    wr_val_r      <= wr_val_nxt;
    val_r         <= val_nxt;
    pos_r         <= pos_nxt;
    err_r         <= err_nxt;
    dst_r         <= dst_nxt;
    wr_dst_r      <= wr_dst_nxt;
    rd_pos_r      <= rd_pos_nxt;
    rd_last_r     <= rd_last_nxt;
    out_status_r  <= out_status_nxt;
    out_present_r <= out_present_nxt;
    out_epos_r    <= out_epos_nxt;
    out_value_r   <= out_value_nxt;
    out_empty_r   <= out_empty_nxt;
    out_last_r    <= out_last_nxt;
  end

  alir_store #(
    .DEPTH (CAPACITY),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - WORD_W - EPOS_W){1'b0}}, out_value_r, out_epos_r};
  assign out_tuser  = {out_empty_r, out_present_r, out_status_r};
  assign out_tlast  = out_last_r;

  // The list never grows beyond its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  // A pending shift write only exists while shifting or just as the commit starts.
  a_wr_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_SHIFT || state_r == S_FIN))
    else $error("shift write outside the shift phase");

  // An accepted command always takes the block out of idle for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted twice in a row");

  // A word in flight from the store belongs to the emission phase.
  a_rd_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == S_EMIT)
    else $error("read pending outside emission");

  // A result carrying an entry is never marked as coming from an empty list.
  a_present_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_present_r) |-> (!out_empty_r && out_status_r == ST_OK))
    else $error("entry result with empty or error flags");

endmodule

>>> sv/alir_store.sv
// Entry store: one write port and one registered read port.
module alir_store
  import alir_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int IW    = 3
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read register holds its value while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
